@@ design/d2i_pkg.sv @@
// Package: shared types and codes for the double to int64 converter.
`timescale 1ns / 1ps
package d2i_pkg;

  localparam logic [1:0] ModeExact = 2'd0;
  localparam logic [1:0] ModeFloor = 2'd1;
  localparam logic [1:0] ModeCeil  = 2'd2;

  localparam logic [1:0] KindInt   = 2'd0;
  localparam logic [1:0] KindDbl   = 2'd1;
  localparam logic [1:0] KindOther = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  value_kind;
    logic [63:0] value_bits;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic signed [63:0] int_result;
  } out_t;

  // Stage 1 -> stage 2: decoded fields and shift amount.
  typedef struct packed {
    logic        is_int;
    logic        fail;
    logic        special_min;
    logic        neg;
    logic [1:0]  mode;
    logic        left;
    logic [6:0]  sh;
    logic        sh_big;
    logic [52:0] sig;
    logic [63:0] raw;
  } dec_t;

  // Stage 2 -> stage 3: integer magnitude and sticky flag.
  typedef struct packed {
    logic        is_int;
    logic        fail;
    logic        special_min;
    logic        neg;
    logic [1:0]  mode;
    logic        frac;
    logic [63:0] ipart;
  } shf_t;

endpackage

@@ design/d2i_decode.sv @@
// Decode stage: splits the double into fields and computes the shift amount.
`timescale 1ns / 1ps
module d2i_decode (
  input  d2i_pkg::in_t  in_i,
  output d2i_pkg::dec_t dec_o
);
  import d2i_pkg::*;

  logic [10:0] ex;
  logic [51:0] man;
  logic [11:0] rsh;

  always_comb begin
    ex  = in_i.value_bits[62:52];
    man = in_i.value_bits[51:0];
    rsh = (ex != 11'd0) ? (12'd1075 - {1'b0, ex}) : 12'd1074;
    dec_o = '0;
    dec_o.raw         = in_i.value_bits;
    dec_o.is_int      = (in_i.value_kind == KindInt);
    dec_o.neg         = in_i.value_bits[63];
    dec_o.mode        = in_i.mode;
    dec_o.sig         = {(ex != 11'd0), man};
    dec_o.left        = (ex >= 11'd1075);
    if (in_i.value_kind != KindInt && in_i.value_kind != KindDbl) begin
      dec_o.fail = 1'b1;
    end else if (in_i.value_kind == KindDbl) begin
      if (ex == 11'h7FF) begin
        dec_o.fail = 1'b1;
      end else if (ex >= 11'd1075) begin
        dec_o.sh = 7'(ex - 11'd1075);
        if (ex > 11'd1086) begin
          dec_o.fail = 1'b1;
        end else if (ex == 11'd1086) begin
          if (in_i.value_bits[63] && man == 52'd0) dec_o.special_min = 1'b1;
          else dec_o.fail = 1'b1;
        end
      end else begin
        dec_o.sh_big = (rsh >= 12'd64);
        dec_o.sh     = 7'(rsh[5:0]);
      end
    end
  end

endmodule

@@ design/d2i_shift.sv @@
// Shift stage: aligns the significand and collects the sticky fraction bit.
`timescale 1ns / 1ps
module d2i_shift (
  input  d2i_pkg::dec_t dec_i,
  output d2i_pkg::shf_t shf_o
);
  import d2i_pkg::*;

  logic [63:0] sig64;
  logic [63:0] mask;

  always_comb begin
    sig64 = {11'd0, dec_i.sig};
    mask  = (64'd1 << dec_i.sh[5:0]) - 64'd1;
    shf_o.is_int      = dec_i.is_int;
    shf_o.fail        = dec_i.fail;
    shf_o.special_min = dec_i.special_min;
    shf_o.neg         = dec_i.neg;
    shf_o.mode        = dec_i.mode;
    if (dec_i.is_int) begin
      shf_o.ipart = dec_i.raw;
      shf_o.frac  = 1'b0;
    end else if (dec_i.left) begin
      shf_o.ipart = sig64 << dec_i.sh[5:0];
      shf_o.frac  = 1'b0;
    end else if (dec_i.sh_big) begin
      shf_o.ipart = '0;
      shf_o.frac  = (sig64 != 64'd0);
    end else begin
      shf_o.ipart = sig64 >> dec_i.sh[5:0];
      shf_o.frac  = ((sig64 & mask) != 64'd0);
    end
  end

endmodule

@@ design/d2i_round.sv @@
// Round stage: applies sign and rounding mode and forms the result.
`timescale 1ns / 1ps
module d2i_round (
  input  d2i_pkg::shf_t shf_i,
  output d2i_pkg::out_t res_o
);
  import d2i_pkg::*;

  logic [63:0] v;
  logic        ok;

  always_comb begin
    v  = shf_i.neg ? (64'd0 - shf_i.ipart) : shf_i.ipart;
    ok = 1'b1;
    if (shf_i.is_int) begin
      v = shf_i.ipart;
    end else if (shf_i.fail) begin
      ok = 1'b0;
    end else if (shf_i.special_min) begin
      v = 64'h8000_0000_0000_0000;
    end else if (shf_i.frac) begin
      if (shf_i.mode == ModeExact) begin
        ok = 1'b0;
      end else begin
        // neg-1 then +1 cancel for ceiling of negatives
        unique case ({shf_i.neg, shf_i.mode == ModeCeil})
          2'b10:   v = v - 64'd1;
          2'b01:   v = v + 64'd1;
          default: v = v;
        endcase
      end
    end
    res_o.ok         = ok;
    res_o.int_result = ok ? v : 64'd0;
  end

endmodule

@@ design/double_to_int64_rounding_convert.sv @@
// Top level: pipelined double/int64 to int64 converter with exact/floor/ceiling modes.
`timescale 1ns / 1ps
// Converts a tagged 64-bit value to a signed 64-bit integer. Integers pass
// through; doubles are floored, and a fractional value fails in exact mode or
// is bumped up by one in ceiling mode. NaN, infinity, out-of-range values and
// other tags give ok = 0 with a zero result. One transaction is accepted per
// cycle while in_stall_o is low; results pass through decode, shift and round registers.
// A stall at the output holds a stage only when that stage and every stage
// after it hold results, so bubbles are squeezed out and nothing is lost or repeated.
module double_to_int64_rounding_convert (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  d2i_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output d2i_pkg::out_t  out_data_o
);
  import d2i_pkg::*;

  dec_t dec_d, dec_q;
  shf_t shf_d, shf_q;
  out_t res_d, res_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  d2i_decode u_dec (.in_i(in_data_i), .dec_o(dec_d));
  d2i_shift  u_shf (.dec_i(dec_q), .shf_o(shf_d));
  d2i_round  u_rnd (.shf_i(shf_q), .res_o(res_d));

  // Each stage loads when it is empty or the stage after it is empty or moving.
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = v3_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) dec_q <= dec_d;
    if (en2) shf_q <= shf_d;
    if (en3) res_q <= res_d;
  end

endmodule

@@ design/d2i_checker.sv @@
// Checker: port-level properties of the converter, bound to the top level.
`timescale 1ns / 1ps
module d2i_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input d2i_pkg::out_t out_data_o,
  input logic          out_valid_o,
  input logic          out_stall_i
);
  import d2i_pkg::*;

  // A failed conversion always reports zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.int_result == 64'd0)
    else $error("failed result not zero");

  // Input is only stalled when the output side is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // A transaction accepted while the output is not stalled passes the decode, shift and round registers to the output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("result missing after latency");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind double_to_int64_rounding_convert d2i_checker u_d2i_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

@@ bench/double_to_int64_rounding_convert_tb.sv @@
// Testbench for the double/int64 to int64 converter: directed table plus random traffic.
`timescale 1ns / 1ps
module double_to_int64_rounding_convert_tb;
  import d2i_pkg::*;

  localparam int NumRandom = 550;
  localparam int Latency   = 3;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  out_t  out_data_o;

  // Directed rows: stimulus plus an optional typed-in expectation.
  typedef struct {
    in_t  stim;
    logic has_exp;
    out_t exp;
  } row_t;

  out_t conv_expected_q[$];
  int   fail_count = 0;
  bit   quiet_phase = 1'b0;
  bit   hold_rx = 1'b0;

  double_to_int64_rounding_convert dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #10 clk_i = ~clk_i;

  // Predicted conversion result, decoded from the double's bit fields.
  function automatic out_t convert_value(in_t t);
    out_t        r;
    logic        neg;
    logic [10:0] ex;
    logic [51:0] man;
    logic [63:0] sig, ipart, v;
    logic        frac;
    int          sh;
    r = '0;
    if (t.value_kind == KindInt) begin
      r.ok = 1'b1;
      r.int_result = t.value_bits;
      return r;
    end
    if (t.value_kind != KindDbl) return r;
    neg = t.value_bits[63];
    ex  = t.value_bits[62:52];
    man = t.value_bits[51:0];
    if (ex == 11'h7ff) return r;
    sig = (ex != 0) ? {11'd0, 1'b1, man} : {12'd0, man};
    if (ex >= 1075) begin
      sh = ex - 1075;
      if (sh > 11) return r;
      if (sh == 11) begin
        // only -2^63 survives at this exponent
        if (neg && man == 0) begin
          r.ok = 1'b1;
          r.int_result = 64'h8000_0000_0000_0000;
        end
        return r;
      end
      ipart = sig << sh;
      frac  = 1'b0;
    end else begin
      sh = (ex != 0) ? (1075 - ex) : 1074;
      if (sh >= 64) begin
        ipart = '0;
        frac  = (sig != 0);
      end else begin
        ipart = sig >> sh;
        frac  = (sig & ((64'd1 << sh) - 64'd1)) != 0;
      end
    end
    v = neg ? -ipart : ipart;
    if (frac) begin
      if (t.mode == ModeExact) return r;
      if (neg) v = v - 64'd1;
      if (t.mode == ModeCeil) v = v + 64'd1;
    end
    r.ok = 1'b1;
    r.int_result = v;
    return r;
  endfunction

  function automatic in_t mk(logic [1:0] m, logic [1:0] k, logic [63:0] b);
    in_t t;
    t.mode = m;
    t.value_kind = k;
    t.value_bits = b;
    return t;
  endfunction

  // Random double aimed at the interesting exponent band around the int64 range.
  function automatic logic [63:0] rand_double();
    logic [63:0] b;
    int          sel;
    b = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (sel < 6) b[62:52] = 11'($urandom_range(1000, 1090));
    else if (sel == 6) b[62:52] = 11'($urandom_range(0, 1));
    else if (sel == 7) b[62:52] = 11'h7ff;
    else if (sel == 8) b[51:0] = '0;
    return b;
  endfunction

  // Send one transaction, holding it until accepted.
  task automatic send_value(in_t t);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    conv_expected_q.push_back(convert_value(t));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_row(row_t rw);
    out_t p;
    p = convert_value(rw.stim);
    if (rw.has_exp && p !== rw.exp) begin
      $error("table row: ok exp %0b act %0b, int_result exp %0h act %0h",
             rw.exp.ok, p.ok, rw.exp.int_result, p.int_result);
      fail_count++;
    end
    send_value(rw.stim);
  endtask

  // Output side: random stall bursts, one long hold-off, and the compare.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_stall_i <= 1'b1;
        repeat (40) @(negedge clk_i);
        hold_rx = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (conv_expected_q.size() == 0) begin
        $error("unexpected transaction: ok %0b int_result %0h",
               out_data_o.ok, out_data_o.int_result);
        fail_count++;
      end else begin
        e = conv_expected_q.pop_front();
        if (out_data_o.ok !== e.ok) begin
          $error("ok: expected %0b actual %0b", e.ok, out_data_o.ok);
          fail_count++;
        end
        if (out_data_o.int_result !== e.int_result) begin
          $error("int_result: expected %0h actual %0h", e.int_result,
                 out_data_o.int_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    in_t  t;
    int   n;
    // Directed table: extremes of the payload, every mode and kind, special cases.
    rows = '{
      '{mk(ModeExact, KindInt, 64'h0), 1, '{1'b1, 64'h0}},
      '{mk(ModeCeil, KindInt, 64'hffff_ffff_ffff_ffff), 1, '{1'b1, -64'sd1}},
      '{mk(ModeFloor, KindInt, 64'h8000_0000_0000_0000), 1, '{1'b1, 64'h8000_0000_0000_0000}},
      '{mk(ModeExact, KindOther, 64'h3ff0_0000_0000_0000), 1, '{1'b0, 64'h0}},
      '{mk(ModeFloor, 2'd3, 64'h0), 1, '{1'b0, 64'h0}},
      '{mk(ModeExact, KindDbl, 64'h7ff8_0000_0000_0000), 1, '{1'b0, 64'h0}},
      '{mk(ModeCeil, KindDbl, 64'h7ff0_0000_0000_0000), 1, '{1'b0, 64'h0}},
      '{mk(ModeFloor, KindDbl, 64'hfff0_0000_0000_0000), 1, '{1'b0, 64'h0}},
      '{mk(ModeExact, KindDbl, 64'h0), 1, '{1'b1, 64'h0}},
      '{mk(ModeExact, KindDbl, 64'h8000_0000_0000_0000), 1, '{1'b1, 64'h0}},
      '{mk(ModeExact, KindDbl, 64'h3ff0_0000_0000_0000), 1, '{1'b1, 64'd1}},
      '{mk(ModeExact, KindDbl, 64'h3ff8_0000_0000_0000), 1, '{1'b0, 64'h0}},
      '{mk(ModeFloor, KindDbl, 64'h3ff8_0000_0000_0000), 1, '{1'b1, 64'd1}},
      '{mk(ModeCeil, KindDbl, 64'h3ff8_0000_0000_0000), 1, '{1'b1, 64'd2}},
      '{mk(2'd3, KindDbl, 64'hbff8_0000_0000_0000), 1, '{1'b1, -64'sd2}},
      '{mk(ModeCeil, KindDbl, 64'hbff8_0000_0000_0000), 1, '{1'b1, -64'sd1}},
      '{mk(ModeExact, KindDbl, 64'h0000_0000_0000_0001), 1, '{1'b0, 64'h0}},
      '{mk(ModeFloor, KindDbl, 64'h8000_0000_0000_0001), 1, '{1'b1, -64'sd1}},
      '{mk(ModeCeil, KindDbl, 64'h000f_ffff_ffff_ffff), 1, '{1'b1, 64'd1}},
      '{mk(ModeExact, KindDbl, 64'hc3e0_0000_0000_0000), 1, '{1'b1, 64'h8000_0000_0000_0000}},
      '{mk(ModeExact, KindDbl, 64'h43e0_0000_0000_0000), 1, '{1'b0, 64'h0}},
      '{mk(ModeFloor, KindDbl, 64'hc3e0_0000_0000_0001), 1, '{1'b0, 64'h0}},
      '{mk(ModeExact, KindDbl, 64'h43df_ffff_ffff_ffff), 0, '{1'b0, 64'h0}},
      '{mk(ModeCeil, KindDbl, 64'h4330_0000_0000_0001), 0, '{1'b0, 64'h0}},
      '{mk(ModeFloor, KindDbl, 64'h4000_0000_0000_0003), 0, '{1'b0, 64'h0}}
    };
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) check_row(rows[i]);

    // Long receiver hold-off while the sender keeps offering transactions.
    hold_rx = 1'b1;
    for (n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 80) quiet_phase = 1'b1;
      t.mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1:    t.value_kind = KindInt;
        2:       t.value_kind = 2'($urandom_range(2, 3));
        default: t.value_kind = KindDbl;
      endcase
      t.value_bits = (t.value_kind == KindDbl) ? rand_double() : {$urandom, $urandom};
      send_value(t);
    end
    in_valid_i <= 1'b0;
    while (conv_expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
